[src/drkp_pkg.sv]
// Types and constants for the DER RSA private key parser.
// Depends on nothing; used by the top level, its checker and the testbench.
package drkp_pkg;

   localparam logic [3:0] FIELD_COUNT = 4'd9;

   localparam logic [7:0] TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] TAG_INTEGER  = 8'h02;
   localparam logic [7:0] LEN_LONG2    = 8'h82;
   localparam logic [7:0] LEN_LONG_BIT = 8'h80;

   localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
   localparam logic [16:0] HEADER_LEN  = 17'd4;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   localparam logic [1:0] KIND_CONTENT     = 2'd0;
   localparam logic [1:0] KIND_EMPTY_FIELD = 2'd1;
   localparam logic [1:0] KIND_KEY_OK      = 2'd2;
   localparam logic [1:0] KIND_ERROR       = 2'd3;

   localparam logic [2:0] ERR_NOT_SEQUENCE = 3'd0;
   localparam logic [2:0] ERR_SEQ_LEN_FORM = 3'd1;
   localparam logic [2:0] ERR_TOTAL_LEN    = 3'd2;
   localparam logic [2:0] ERR_NOT_INTEGER  = 3'd3;
   localparam logic [2:0] ERR_LEN_FORM     = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED    = 3'd5;
   localparam logic [2:0] ERR_NONE         = 3'd0;

   typedef enum logic [9:0] {
      PH_SEQ_TAG  = 10'b00_0000_0001,
      PH_SEQ_FORM = 10'b00_0000_0010,
      PH_SEQ_HI   = 10'b00_0000_0100,
      PH_SEQ_LO   = 10'b00_0000_1000,
      PH_INT_TAG  = 10'b00_0001_0000,
      PH_INT_LEN  = 10'b00_0010_0000,
      PH_INT_HI   = 10'b00_0100_0000,
      PH_INT_LO   = 10'b00_1000_0000,
      PH_CONTENT  = 10'b01_0000_0000,
      PH_DONE     = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] field_index;
      logic [7:0] value;
      logic       field_end;
      logic [2:0] error_code;
      logic       last;
   } rsp_word_type;

endpackage

[src/drkp_if.sv]
// Handshake channels of the DER RSA private key parser: key bytes in, results out.
// Depends on nothing.
interface drkp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   logic       final_byte;

   modport source (output valid, output data, output final_byte, input ready);
   modport sink   (input valid, input data, input final_byte, output ready);
endinterface

interface drkp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [3:0] field_index;
   logic [7:0] value;
   logic       field_end;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output kind, output field_index, output value,
                   output field_end, output error_code, output last, input ready);
   modport sink   (input valid, input kind, input field_index, input value,
                   input field_end, input error_code, input last, output ready);
endinterface

[src/der_rsa_private_key_parser_top.sv]
// Parser for DER encoded PKCS#1 RSA private keys, one byte per word.
// Depends on drkp_pkg and the channel interfaces in drkp_if.sv.
//
// The block takes one key byte per clock cycle while req_ch.ready is high and
// updates its parse state in that same cycle; each byte yields zero, one or two
// result words, which wait in a four-entry result queue. Only the final byte of
// a key can yield two words (a content or empty-field word and the verdict),
// and it writes both into the queue at once; req_ch.ready is low while the queue
// holds three or more words. Results are registered in the queue before they
// appear on rsp_ch. After an error, later bytes give nothing, the final byte
// included; after the final byte the parser is ready for the next key.
module der_rsa_private_key_parser_top (
   input  logic               clock,
   input  logic               reset,
   drkp_req_if.sink           req_ch,
   drkp_rsp_if.source         rsp_ch
);

   drkp_pkg::phase_type    phase_ff, phase_in;
   logic [3:0]             field_ff, field_in;
   logic [15:0]            bytes_left_ff, bytes_left_in;
   logic [15:0]            seq_len_ff, seq_len_in;
   logic [16:0]            count_ff, count_in;
   logic                   failed_ff, failed_in;

   drkp_pkg::rsp_word_type queue_ff [drkp_pkg::RSP_DEPTH];
   logic [drkp_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [drkp_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [drkp_pkg::RSP_CNT_W-1:0] fill_ff, fill_in;

   drkp_pkg::rsp_word_type pars_word, fin_word, word0, word1;
   logic                   pars_vld, fin_vld;
   logic [1:0]             push_n;
   logic                   accept, pop;
   logic [7:0]             d;
   logic [15:0]            bl_dec, start_len;
   logic                   start_en;
   logic [3:0]             field_inc;
   logic                   header_phase;

   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign d      = req_ch.data;
   assign bl_dec = bytes_left_ff - 16'd1;
   assign field_inc = field_ff + 4'd1;

   assign req_ch.ready = fill_ff <= drkp_pkg::RSP_CNT_W'(drkp_pkg::RSP_DEPTH - 2);

   always_comb begin
      phase_in      = phase_ff;
      field_in      = field_ff;
      bytes_left_in = bytes_left_ff;
      seq_len_in    = seq_len_ff;
      failed_in     = failed_ff;
      count_in      = (count_ff == drkp_pkg::COUNT_MAX) ? count_ff : count_ff + 17'd1;
      pars_vld      = 1'b0;
      pars_word     = '0;
      fin_vld       = 1'b0;
      fin_word      = '0;
      start_en      = 1'b0;
      start_len     = 16'd0;
      header_phase  = 1'b0;

      if (!failed_ff) begin
         case (phase_ff)
            drkp_pkg::PH_SEQ_TAG: begin
               if (d != drkp_pkg::TAG_SEQUENCE) begin
                  pars_vld              = 1'b1;
                  pars_word.kind        = drkp_pkg::KIND_ERROR;
                  pars_word.field_index = field_ff;
                  pars_word.error_code  = drkp_pkg::ERR_NOT_SEQUENCE;
                  failed_in             = 1'b1;
               end else begin
                  phase_in = drkp_pkg::PH_SEQ_FORM;
               end
            end
            drkp_pkg::PH_SEQ_FORM: begin
               if (d != drkp_pkg::LEN_LONG2) begin
                  pars_vld              = 1'b1;
                  pars_word.kind        = drkp_pkg::KIND_ERROR;
                  pars_word.field_index = field_ff;
                  pars_word.error_code  = drkp_pkg::ERR_SEQ_LEN_FORM;
                  failed_in             = 1'b1;
               end else begin
                  phase_in = drkp_pkg::PH_SEQ_HI;
               end
            end
            drkp_pkg::PH_SEQ_HI: begin
               seq_len_in = {d, 8'h00};
               phase_in   = drkp_pkg::PH_SEQ_LO;
            end
            drkp_pkg::PH_SEQ_LO: begin
               seq_len_in = {seq_len_ff[15:8], d};
               phase_in   = drkp_pkg::PH_INT_TAG;
            end
            drkp_pkg::PH_INT_TAG: begin
               if (d != drkp_pkg::TAG_INTEGER) begin
                  pars_vld              = 1'b1;
                  pars_word.kind        = drkp_pkg::KIND_ERROR;
                  pars_word.field_index = field_ff;
                  pars_word.error_code  = drkp_pkg::ERR_NOT_INTEGER;
                  failed_in             = 1'b1;
               end else begin
                  phase_in = drkp_pkg::PH_INT_LEN;
               end
            end
            drkp_pkg::PH_INT_LEN: begin
               if ((d & drkp_pkg::LEN_LONG_BIT) == 8'h00) begin
                  start_en  = 1'b1;
                  start_len = {8'h00, d};
               end else if (d == drkp_pkg::LEN_LONG2) begin
                  phase_in = drkp_pkg::PH_INT_HI;
               end else begin
                  pars_vld              = 1'b1;
                  pars_word.kind        = drkp_pkg::KIND_ERROR;
                  pars_word.field_index = field_ff;
                  pars_word.error_code  = drkp_pkg::ERR_LEN_FORM;
                  failed_in             = 1'b1;
               end
            end
            drkp_pkg::PH_INT_HI: begin
               bytes_left_in = {d, 8'h00};
               phase_in      = drkp_pkg::PH_INT_LO;
            end
            drkp_pkg::PH_INT_LO: begin
               start_en  = 1'b1;
               start_len = {bytes_left_ff[15:8], d};
            end
            drkp_pkg::PH_CONTENT: begin
               bytes_left_in         = bl_dec;
               pars_vld              = 1'b1;
               pars_word.kind        = drkp_pkg::KIND_CONTENT;
               pars_word.field_index = field_ff;
               pars_word.value       = d;
               pars_word.field_end   = (bl_dec == 16'd0);
               if (bl_dec == 16'd0) begin
                  field_in = field_inc;
                  phase_in = (field_inc >= drkp_pkg::FIELD_COUNT) ? drkp_pkg::PH_DONE
                                                                 : drkp_pkg::PH_INT_TAG;
               end
            end
            default: begin
            end
         endcase

         if (start_en) begin
            if (start_len == 16'd0) begin
               pars_vld              = 1'b1;
               pars_word.kind        = drkp_pkg::KIND_EMPTY_FIELD;
               pars_word.field_index = field_ff;
               pars_word.field_end   = 1'b1;
               field_in              = field_inc;
               phase_in = (field_inc >= drkp_pkg::FIELD_COUNT) ? drkp_pkg::PH_DONE
                                                              : drkp_pkg::PH_INT_TAG;
            end else begin
               bytes_left_in = start_len;
               phase_in      = drkp_pkg::PH_CONTENT;
            end
         end
      end

      if (req_ch.final_byte) begin
         header_phase = (phase_in == drkp_pkg::PH_SEQ_TAG) || (phase_in == drkp_pkg::PH_SEQ_FORM)
                     || (phase_in == drkp_pkg::PH_SEQ_HI) || (phase_in == drkp_pkg::PH_SEQ_LO);
         if (!failed_in) begin
            fin_vld = 1'b1;
            if (!header_phase && ({1'b0, seq_len_in} + drkp_pkg::HEADER_LEN != count_in)) begin
               fin_word.kind        = drkp_pkg::KIND_ERROR;
               fin_word.field_index = field_in;
               fin_word.error_code  = drkp_pkg::ERR_TOTAL_LEN;
            end else if (phase_in != drkp_pkg::PH_DONE) begin
               fin_word.kind        = drkp_pkg::KIND_ERROR;
               fin_word.field_index = field_in;
               fin_word.error_code  = drkp_pkg::ERR_TRUNCATED;
            end else begin
               fin_word.kind = drkp_pkg::KIND_KEY_OK;
            end
            fin_word.last = 1'b1;
         end
         phase_in      = drkp_pkg::PH_SEQ_TAG;
         field_in      = 4'd0;
         bytes_left_in = 16'd0;
         seq_len_in    = 16'd0;
         count_in      = 17'd0;
         failed_in     = 1'b0;
      end

      pars_word.last = !fin_vld;
   end

   always_comb begin
      word0  = fin_word;
      word1  = fin_word;
      push_n = {1'b0, fin_vld};
      if (pars_vld) begin
         word0  = pars_word;
         push_n = fin_vld ? 2'd2 : 2'd1;
      end
      if (!accept) begin
         push_n = 2'd0;
      end
      wr_ptr_in = wr_ptr_ff + drkp_pkg::RSP_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + drkp_pkg::RSP_PTR_W'(pop);
      fill_in   = fill_ff + drkp_pkg::RSP_CNT_W'(push_n) - drkp_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= drkp_pkg::PH_SEQ_TAG;
         field_ff      <= 4'd0;
         bytes_left_ff <= 16'd0;
         seq_len_ff    <= 16'd0;
         count_ff      <= 17'd0;
         failed_ff     <= 1'b0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            field_ff      <= field_in;
            bytes_left_ff <= bytes_left_in;
            seq_len_ff    <= seq_len_in;
            count_ff      <= count_in;
            failed_ff     <= failed_in;
         end
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= word0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + drkp_pkg::RSP_PTR_W'(1)] <= word1;
      end
   end

   assign rsp_ch.valid       = fill_ff != '0;
   assign rsp_ch.kind        = queue_ff[rd_ptr_ff].kind;
   assign rsp_ch.field_index = queue_ff[rd_ptr_ff].field_index;
   assign rsp_ch.value       = queue_ff[rd_ptr_ff].value;
   assign rsp_ch.field_end   = queue_ff[rd_ptr_ff].field_end;
   assign rsp_ch.error_code  = queue_ff[rd_ptr_ff].error_code;
   assign rsp_ch.last        = queue_ff[rd_ptr_ff].last;

endmodule

[src/drkp_chk.sv]
// Port-level checker for the DER RSA private key parser, bound to its top level.
// Depends on drkp_pkg and der_rsa_private_key_parser_top.
module drkp_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [3:0] rsp_field_index,
   input logic [7:0] rsp_value,
   input logic       rsp_field_end,
   input logic [2:0] rsp_error_code,
   input logic       rsp_last
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result queue not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value)
         && $stable(rsp_field_index) && $stable(rsp_last))
      else $error("stalled result word changed");

   a_verdict_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == drkp_pkg::KIND_KEY_OK || rsp_kind == drkp_pkg::KIND_ERROR)
         |-> rsp_last && !rsp_field_end && rsp_value == 8'h00)
      else $error("verdict word malformed");

   a_field_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == drkp_pkg::KIND_CONTENT || rsp_kind == drkp_pkg::KIND_EMPTY_FIELD)
         |-> rsp_error_code == drkp_pkg::ERR_NONE && rsp_field_index < drkp_pkg::FIELD_COUNT)
      else $error("field word malformed");

endmodule

bind der_rsa_private_key_parser_top drkp_chk u_drkp_chk (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_kind        (rsp_ch.kind),
   .rsp_field_index (rsp_ch.field_index),
   .rsp_value       (rsp_ch.value),
   .rsp_field_end   (rsp_ch.field_end),
   .rsp_error_code  (rsp_ch.error_code),
   .rsp_last        (rsp_ch.last)
);

[test/tb_der_rsa_private_key_parser_top.sv]
// Testbench for der_rsa_private_key_parser_top: drives DER key bytes with random gaps and
// stalls, predicts every result word and checks each one as it leaves the block.
// Depends on drkp_pkg, the channel interfaces in drkp_if.sv and the top level.
`timescale 1ns / 1ps

module tb_der_rsa_private_key_parser_top;

   typedef logic [7:0] key_buf_type[$];

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PRINT_CAP = 100;
   localparam int unsigned FIELDS = int'(drkp_pkg::FIELD_COUNT);

   class key_parse_scoreboard;
      drkp_pkg::phase_type    stage;
      logic [3:0]             field_no;
      logic [15:0]            remaining;
      logic [15:0]            seq_total;
      logic [16:0]            seen;
      bit                     broken;
      drkp_pkg::rsp_word_type byte_words[$];
      drkp_pkg::rsp_word_type expected_words[$];
      int unsigned            mismatches;
      int unsigned            words_checked;

      function new();
         clear_state();
         mismatches = 0;
         words_checked = 0;
      endfunction

      function void clear_state();
         stage = drkp_pkg::PH_SEQ_TAG;
         field_no = 4'd0;
         remaining = 16'd0;
         seq_total = 16'd0;
         seen = 17'd0;
         broken = 1'b0;
      endfunction

      function void queue_word(logic [1:0] k, logic [3:0] fi, logic [7:0] v, logic fe,
                               logic [2:0] ec);
         drkp_pkg::rsp_word_type w;
         w.kind = k;
         w.field_index = fi;
         w.value = v;
         w.field_end = fe;
         w.error_code = ec;
         w.last = 1'b0;
         byte_words = {byte_words, w};
      endfunction

      function void fail_key(logic [2:0] code);
         queue_word(drkp_pkg::KIND_ERROR, field_no, 8'h00, 1'b0, code);
         broken = 1'b1;
      endfunction

      function void next_field();
         field_no = field_no + 4'd1;
         stage = (field_no >= drkp_pkg::FIELD_COUNT) ? drkp_pkg::PH_DONE
                                                     : drkp_pkg::PH_INT_TAG;
      endfunction

      function void open_field(logic [15:0] len);
         if (len == 16'd0) begin
            queue_word(drkp_pkg::KIND_EMPTY_FIELD, field_no, 8'h00, 1'b1, drkp_pkg::ERR_NONE);
            next_field();
         end else begin
            remaining = len;
            stage = drkp_pkg::PH_CONTENT;
         end
      endfunction

      function void note_byte(logic [7:0] d, logic fin);
         byte_words.delete();
         if (seen != drkp_pkg::COUNT_MAX) seen = seen + 17'd1;
         if (!broken) begin
            case (stage)
               drkp_pkg::PH_SEQ_TAG: begin
                  if (d != drkp_pkg::TAG_SEQUENCE) fail_key(drkp_pkg::ERR_NOT_SEQUENCE);
                  else stage = drkp_pkg::PH_SEQ_FORM;
               end
               drkp_pkg::PH_SEQ_FORM: begin
                  if (d != drkp_pkg::LEN_LONG2) fail_key(drkp_pkg::ERR_SEQ_LEN_FORM);
                  else stage = drkp_pkg::PH_SEQ_HI;
               end
               drkp_pkg::PH_SEQ_HI: begin
                  seq_total = {d, 8'h00};
                  stage = drkp_pkg::PH_SEQ_LO;
               end
               drkp_pkg::PH_SEQ_LO: begin
                  seq_total[7:0] = d;
                  stage = drkp_pkg::PH_INT_TAG;
               end
               drkp_pkg::PH_INT_TAG: begin
                  if (d != drkp_pkg::TAG_INTEGER) fail_key(drkp_pkg::ERR_NOT_INTEGER);
                  else stage = drkp_pkg::PH_INT_LEN;
               end
               drkp_pkg::PH_INT_LEN: begin
                  if (d < drkp_pkg::LEN_LONG_BIT) open_field({8'h00, d});
                  else if (d == drkp_pkg::LEN_LONG2) stage = drkp_pkg::PH_INT_HI;
                  else fail_key(drkp_pkg::ERR_LEN_FORM);
               end
               drkp_pkg::PH_INT_HI: begin
                  remaining = {d, 8'h00};
                  stage = drkp_pkg::PH_INT_LO;
               end
               drkp_pkg::PH_INT_LO: begin
                  open_field({remaining[15:8], d});
               end
               drkp_pkg::PH_CONTENT: begin
                  remaining = remaining - 16'd1;
                  queue_word(drkp_pkg::KIND_CONTENT, field_no, d, remaining == 16'd0,
                             drkp_pkg::ERR_NONE);
                  if (remaining == 16'd0) next_field();
               end
               default: begin
               end
            endcase
         end
         if (fin) begin
            if (!broken) begin
               if (!(stage inside {drkp_pkg::PH_SEQ_TAG, drkp_pkg::PH_SEQ_FORM,
                                   drkp_pkg::PH_SEQ_HI, drkp_pkg::PH_SEQ_LO}) &&
                   ({1'b0, seq_total} + drkp_pkg::HEADER_LEN != seen))
                  fail_key(drkp_pkg::ERR_TOTAL_LEN);
               else if (stage != drkp_pkg::PH_DONE)
                  fail_key(drkp_pkg::ERR_TRUNCATED);
               else
                  queue_word(drkp_pkg::KIND_KEY_OK, 4'd0, 8'h00, 1'b0, drkp_pkg::ERR_NONE);
            end
            clear_state();
         end
         if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last = 1'b1;
         expected_words = {expected_words, byte_words};
      endfunction

      task flag_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_word(drkp_pkg::rsp_word_type got);
         drkp_pkg::rsp_word_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            flag_mismatch($sformatf("word %0d unexpected: kind %0d field %0d value %02h",
                                    words_checked, got.kind, got.field_index, got.value));
         end else begin
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.field_index !== want.field_index ||
                got.value !== want.value || got.field_end !== want.field_end ||
                got.error_code !== want.error_code || got.last !== want.last)
               flag_mismatch($sformatf(
                  "word %0d got k%0d f%0d v%02h e%0d c%0d l%0d want k%0d f%0d v%02h e%0d c%0d l%0d",
                  words_checked, got.kind, got.field_index, got.value, got.field_end,
                  got.error_code, got.last, want.kind, want.field_index, want.value,
                  want.field_end, want.error_code, want.last));
         end
      endtask

      task flag_leftovers();
         foreach (expected_words[i])
            flag_mismatch($sformatf("word never came: kind %0d field %0d value %02h",
                                    expected_words[i].kind, expected_words[i].field_index,
                                    expected_words[i].value));
      endtask
   endclass

   logic clock;
   logic reset;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned taken_bytes;
   int unsigned cycle_count;
   key_parse_scoreboard ledger = new();

   drkp_req_if req_ch();
   drkp_rsp_if rsp_ch();

   der_rsa_private_key_parser_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   initial begin : watch_results
      drkp_pkg::rsp_word_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.kind = rsp_ch.kind;
            got.field_index = rsp_ch.field_index;
            got.value = rsp_ch.value;
            got.field_end = rsp_ch.field_end;
            got.error_code = rsp_ch.error_code;
            got.last = rsp_ch.last;
            ledger.check_word(got);
         end
      end
   end

   function automatic key_buf_type build_key(int unsigned nfields, int unsigned max_len,
                                             logic [15:0] long_mask, int unsigned big_len,
                                             int unsigned trailing);
      key_buf_type key;
      int unsigned len;
      logic [16:0] body;
      key = {drkp_pkg::TAG_SEQUENCE, drkp_pkg::LEN_LONG2, 8'h00, 8'h00};
      for (int i = 0; i < int'(nfields); i++) begin
         len = (i == 1 && big_len != 0) ? big_len : $urandom_range(max_len, 0);
         key = {key, drkp_pkg::TAG_INTEGER};
         if (len >= 128 || long_mask[i]) begin
            key = {key, drkp_pkg::LEN_LONG2, len[15:8], len[7:0]};
         end else begin
            key = {key, len[7:0]};
         end
         repeat (len) key = {key, 8'($urandom)};
      end
      repeat (trailing) key = {key, 8'($urandom)};
      body = 17'(key.size() - 4);
      key[2] = body[15:8];
      key[3] = body[7:0];
      return key;
   endfunction

   // enter and leave at a falling edge
   task automatic send_byte(input logic [7:0] d, input logic fin);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= 8'($urandom);
         req_ch.final_byte <= 1'($urandom);
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= d;
      req_ch.final_byte <= fin;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      ledger.note_byte(d, fin);
      taken_bytes++;
      @(negedge clock);
   endtask

   task automatic send_key(input key_buf_type key);
      foreach (key[i]) send_byte(key[i], i == key.size() - 1);
   endtask

   task automatic send_random_keys(input int unsigned budget);
      key_buf_type key;
      int unsigned goal;
      int unsigned pick;
      int unsigned nf;
      int unsigned cut;
      goal = taken_bytes + budget;
      while (taken_bytes < goal) begin
         pick = $urandom_range(99);
         nf = (pick >= 75 && pick < 85) ? $urandom_range(FIELDS + 2, 0) : FIELDS;
         key = build_key(nf, ($urandom_range(3) == 0) ? 8 : 2,
                         ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000,
                         ($urandom_range(19) == 0) ? $urandom_range(300, 128) : 0,
                         ($urandom_range(9) == 0) ? $urandom_range(4, 1) : 0);
         if (pick >= 55 && pick < 65) begin
            key[3] = key[3] ^ 8'($urandom_range(255, 1));
         end else if (pick >= 65 && pick < 75) begin
            key[$urandom_range(key.size() - 1, 0)] = 8'($urandom);
         end else if (pick >= 85 && pick < 93) begin
            cut = $urandom_range(key.size() - 1, 1);
            while (key.size() > cut) void'(key.pop_back());
         end else if (pick >= 93) begin
            key = {};
            repeat ($urandom_range(12, 1)) key = {key, 8'($urandom)};
            if ($urandom_range(1) == 1) key[0] = drkp_pkg::TAG_SEQUENCE;
         end
         send_key(key);
      end
   endtask

   initial begin : stimulus
      key_buf_type key;
      logic [7:0] bad_forms[4];
      int unsigned waited;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = 8'h00;
      req_ch.final_byte = 1'b0;
      sender_idle_pct = 6;
      receiver_idle_pct = 76;
      taken_bytes = 0;
      bad_forms = '{8'h80, 8'h81, 8'h83, 8'hFF};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_key(build_key(FIELDS, 0, 16'h0000, 0, 0));
      send_key(build_key(FIELDS, 0, 16'hFFFF, 0, 0));
      send_key(build_key(FIELDS, 3, 16'hFFFF, 0, 0));
      send_key(build_key(FIELDS, 2, 16'h0000, 200, 2));
      key = build_key(FIELDS, 1, 16'h0000, 0, 0);
      key[3] = key[3] + 8'd1;
      send_key(key);
      send_key(build_key(3, 1, 16'h0000, 0, 0));
      send_key(build_key(FIELDS + 1, 1, 16'h0000, 0, 0));
      key = {8'h31, drkp_pkg::TAG_SEQUENCE, drkp_pkg::LEN_LONG2, 8'h00};
      send_key(key);
      key = {8'h00};
      send_key(key);
      key = {drkp_pkg::TAG_SEQUENCE, 8'h81, 8'h00, 8'h10, drkp_pkg::TAG_INTEGER};
      send_key(key);
      key = {drkp_pkg::TAG_SEQUENCE};
      send_key(key);
      key = {drkp_pkg::TAG_SEQUENCE, drkp_pkg::LEN_LONG2, 8'h00};
      send_key(key);
      key = {drkp_pkg::TAG_SEQUENCE, drkp_pkg::LEN_LONG2, 8'h00, 8'h00};
      send_key(key);
      key = {drkp_pkg::TAG_SEQUENCE, drkp_pkg::LEN_LONG2, 8'h00, 8'h03, 8'h03, 8'h01, 8'h00};
      send_key(key);
      key = {drkp_pkg::TAG_SEQUENCE, drkp_pkg::LEN_LONG2, 8'h00, 8'h01, 8'h05};
      send_key(key);
      foreach (bad_forms[i]) begin
         key = {drkp_pkg::TAG_SEQUENCE, drkp_pkg::LEN_LONG2, 8'h00, 8'h03,
                drkp_pkg::TAG_INTEGER, bad_forms[i], 8'h01};
         send_key(key);
      end

      send_random_keys(160);
      sender_idle_pct = 76;
      receiver_idle_pct = 6;
      send_random_keys(160);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      send_random_keys(150);

      req_ch.valid <= 1'b0;
      waited = 0;
      while (ledger.expected_words.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      ledger.flag_leftovers();
      if (ledger.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
